// ----- hw/rtl/xce_pkg.sv -----
package xce_pkg;

  localparam int unsigned CpWidth   = 21;
  localparam int unsigned ModeWidth = 2;
  localparam int unsigned RunWidth  = 2;
  localparam int unsigned IdxWidth  = 3;
  localparam int unsigned AsciiWidth = 7;

  localparam logic [CpWidth-1:0] CH_LT   = CpWidth'('h3C);
  localparam logic [CpWidth-1:0] CH_GT   = CpWidth'('h3E);
  localparam logic [CpWidth-1:0] CH_AMP  = CpWidth'('h26);
  localparam logic [CpWidth-1:0] CH_QUOT = CpWidth'('h22);
  localparam logic [CpWidth-1:0] CH_APOS = CpWidth'('h27);
  localparam logic [CpWidth-1:0] CH_RBRK = CpWidth'('h5D);

  localparam logic [RunWidth-1:0] RunSat = RunWidth'(2);

  typedef enum logic [1:0] {
    MODE_TEXT  = 2'd0,
    MODE_QUOT  = 2'd1,
    MODE_APOS  = 2'd2,
    MODE_SPARE = 2'd3
  } mode_e;

  typedef enum logic [2:0] {
    KIND_PASS,
    KIND_LT,
    KIND_GT,
    KIND_AMP,
    KIND_QUOT,
    KIND_APOS
  } kind_e;

  typedef struct packed {
    logic [CpWidth-1:0]   code_point;
    logic [ModeWidth-1:0] escape_mode;
    logic                 first_of_string;
  } xce_in_t;

  typedef struct packed {
    logic [CpWidth-1:0] out_char;
    logic               last_of_run;
  } xce_out_t;

  // Decides which replacement a character gets. The run argument is the
  // bracket history already cleared for the start of a string.
  function automatic kind_e classify(logic [CpWidth-1:0] cp, logic [ModeWidth-1:0] mode,
                                     logic [RunWidth-1:0] run);
    kind_e kind;
    kind = KIND_PASS;
    if (cp == CH_LT) begin
      kind = KIND_LT;
    end else if (cp == CH_AMP) begin
      kind = KIND_AMP;
    end else if (cp == CH_GT && (mode == MODE_TEXT || mode == MODE_SPARE) && run >= RunSat) begin
      kind = KIND_GT;
    end else if (cp == CH_QUOT && mode == MODE_QUOT) begin
      kind = KIND_QUOT;
    end else if (cp == CH_APOS && mode == MODE_APOS) begin
      kind = KIND_APOS;
    end
    return kind;
  endfunction

  // Number of output characters for a kind, minus one.
  function automatic logic [IdxWidth-1:0] last_idx(kind_e kind);
    logic [IdxWidth-1:0] n;
    case (kind)
      KIND_PASS: n = IdxWidth'(0);
      KIND_LT:   n = IdxWidth'(3);
      KIND_GT:   n = IdxWidth'(3);
      KIND_AMP:  n = IdxWidth'(4);
      KIND_QUOT: n = IdxWidth'(5);
      KIND_APOS: n = IdxWidth'(5);
      default:   n = IdxWidth'(0);
    endcase
    return n;
  endfunction

  // Character at position idx of an entity sequence. Every entity opens
  // with an ampersand and closes with a semicolon.
  function automatic logic [AsciiWidth-1:0] seq_char(kind_e kind, logic [IdxWidth-1:0] idx);
    logic [AsciiWidth-1:0] c;
    c = AsciiWidth'(";");
    case (kind)
      KIND_LT, KIND_GT: begin
        case (idx)
          IdxWidth'(0): c = AsciiWidth'("&");
          IdxWidth'(1): c = (kind == KIND_LT) ? AsciiWidth'("l") : AsciiWidth'("g");
          IdxWidth'(2): c = AsciiWidth'("t");
          default:      c = AsciiWidth'(";");
        endcase
      end
      KIND_AMP: begin
        case (idx)
          IdxWidth'(0): c = AsciiWidth'("&");
          IdxWidth'(1): c = AsciiWidth'("a");
          IdxWidth'(2): c = AsciiWidth'("m");
          IdxWidth'(3): c = AsciiWidth'("p");
          default:      c = AsciiWidth'(";");
        endcase
      end
      KIND_QUOT: begin
        case (idx)
          IdxWidth'(0): c = AsciiWidth'("&");
          IdxWidth'(1): c = AsciiWidth'("q");
          IdxWidth'(2): c = AsciiWidth'("u");
          IdxWidth'(3): c = AsciiWidth'("o");
          IdxWidth'(4): c = AsciiWidth'("t");
          default:      c = AsciiWidth'(";");
        endcase
      end
      KIND_APOS: begin
        case (idx)
          IdxWidth'(0): c = AsciiWidth'("&");
          IdxWidth'(1): c = AsciiWidth'("a");
          IdxWidth'(2): c = AsciiWidth'("p");
          IdxWidth'(3): c = AsciiWidth'("o");
          IdxWidth'(4): c = AsciiWidth'("s");
          default:      c = AsciiWidth'(";");
        endcase
      end
      default: c = AsciiWidth'(";");
    endcase
    return c;
  endfunction

endpackage

// ----- hw/rtl/xce_stream_if.sv -----
interface xce_stream_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hw/rtl/xml_character_escaper.sv -----
// XML character escaper.
// The in_i channel takes one Unicode code point per transaction, together
// with the escape mode of its string and a flag that marks the first
// character of a string. The out_o channel gives the escaped form of that
// character, one code point per transaction, with last_of_run set on the
// final code point that belongs to one input character.
// An accepted character lands in a holding register, where it is classified;
// its output code points then move into the output register, one per cycle
// while the receiver does not stall. A character that passes through
// unchanged has a single output code point, so plain text streams at one
// character per cycle when the receiver keeps up. An escaped character holds
// the holding register until all of its output code points (4 to 6) move on.
// Reset clears the bracket history and empties both registers.
// When the receiver stalls, the output register holds its transaction and
// the holding register stops draining; the input side keeps taking a new
// character in the cycle in which the last code point of the current one
// moves on, so no bubble appears between input characters.
module xml_character_escaper
  import xce_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  xce_stream_if.sink        in_i,
  xce_stream_if.source      out_o
);

  // Holding register: the character being expanded.
  logic                    busy_q, busy_d;
  kind_e                   kind_q, kind_d;
  logic [CpWidth-1:0]      cp_q, cp_d;
  logic [IdxWidth-1:0]     idx_q, idx_d;

  // Bracket history, saturating count of ']' right before the next character.
  logic [RunWidth-1:0]     run_q, run_d;

  // Output register.
  logic                    out_valid_q, out_valid_d;
  xce_out_t                out_q, out_d;

  logic                    in_acc;
  logic                    out_load;
  logic                    at_last;
  logic [RunWidth-1:0]     run_eff;

  assign at_last  = (idx_q == last_idx(kind_q));
  assign out_load = busy_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !busy_q || (out_load && at_last);
  assign in_acc   = in_i.valid && in_i.ready;

  // History is taken as cleared for the first character of a string.
  assign run_eff = in_i.data.first_of_string ? '0 : run_q;

  always_comb begin
    busy_d      = busy_q;
    kind_d      = kind_q;
    cp_d        = cp_q;
    idx_d       = idx_q;
    run_d       = run_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end

    if (out_load) begin
      out_valid_d = 1'b1;
      if (kind_q == KIND_PASS) begin
        out_d.out_char = cp_q;
      end else begin
        out_d.out_char = CpWidth'(seq_char(kind_q, idx_q));
      end
      out_d.last_of_run = at_last;
      if (at_last) begin
        busy_d = 1'b0;
      end else begin
        idx_d = idx_q + IdxWidth'(1);
      end
    end

    if (in_acc) begin
      busy_d = 1'b1;
      idx_d  = '0;
      cp_d   = in_i.data.code_point;
      kind_d = classify(in_i.data.code_point, in_i.data.escape_mode, run_eff);
      if (in_i.data.code_point == CH_RBRK) begin
        run_d = (run_eff >= RunSat) ? RunSat : run_eff + RunWidth'(1);
      end else begin
        run_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      run_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      run_q       <= run_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q <= kind_d;
    cp_q   <= cp_d;
    idx_q  <= idx_d;
    out_q  <= out_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  // A character still expanding blocks the input unless its last code point moves on.
  a_hold_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !(out_load && at_last) |-> !in_i.ready)
    else $error("input taken while a character is still expanding");

  // A '<' always turns into the less-than entity.
  a_lt_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.data.code_point == CH_LT |=> busy_q && kind_q == KIND_LT)
    else $error("'<' not classified for escaping");

  // A ']' leaves a nonzero bracket history behind.
  a_run_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && in_i.data.code_point == CH_RBRK |=> run_q != '0)
    else $error("bracket history lost after ']'");

  // The sequence index stays inside the current entity.
  a_idx_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> idx_q <= last_idx(kind_q))
    else $error("sequence index beyond entity length");

  // A new character is taken while busy only as the previous run's last code point moves on.
  a_last_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && busy_q |-> out_load && at_last)
    else $error("new character accepted before the previous run finished");

endmodule

// ----- sim/xml_character_escaper_test.sv -----
// Testbench for the XML character escaper.
// A short table of hand-picked characters runs first, followed by random
// strings that lean heavily on brackets, angle brackets, ampersands and
// quotes. Every accepted input transaction is fed to a model of the escaper
// kept in this file, which queues the code points that must come out. Each
// output transaction is checked against the oldest queued code point.
module xml_character_escaper_test;
  import xce_pkg::*;

  // Seconds of real work are cheap here; the limit only guards against a hang.
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomChars = 260;
  localparam int unsigned MaxWait     = 12;
  // Cycles to linger once nothing is expected.
  localparam int unsigned DrainCycles = 10;

  typedef struct {
    xce_in_t item;
    bit      pinned;  // The character must come back unchanged as one transaction.
  } char_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  xce_stream_if #(.T(xce_in_t))  in_ch ();
  xce_stream_if #(.T(xce_out_t)) out_ch ();

  xml_character_escaper DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Model state: number of ']' seen just before the next character of the
  // current string, saturating at two.
  logic [RunWidth-1:0] brackets_seen = '0;
  // Code points the escaper still owes us, oldest first.
  xce_out_t            awaited_chars[$];
  char_row_t           directed_rows[$];
  int unsigned         mismatch_count = 0;
  int unsigned         cycle_count = 0;
  // While one of these is non-zero, the matching side does not idle at all.
  int                  calm_in = 0;
  int                  calm_out = 0;

  // Returns the entity that replaces the character, or an empty string when
  // the character passes through, and advances the bracket history.
  function automatic string escape_char(xce_in_t item);
    logic [RunWidth-1:0] prior;
    string               entity;
    // A new string forgets the brackets of the previous one before the
    // character is judged.
    prior = item.first_of_string ? '0 : brackets_seen;
    if (item.code_point == CH_RBRK) begin
      brackets_seen = (prior >= RunSat) ? RunSat : prior + 1'b1;
    end else begin
      brackets_seen = '0;
    end
    entity = "";
    if (item.code_point == CH_LT) begin
      entity = "&lt;";
    end else if (item.code_point == CH_AMP) begin
      entity = "&amp;";
    end else if (item.code_point == CH_GT && prior >= RunSat &&
                 (item.escape_mode == MODE_TEXT || item.escape_mode == MODE_SPARE)) begin
      // Only the "]]>" sequence in a text node needs its '>' escaped; the
      // history survives mode changes, and the spare mode acts as text.
      entity = "&gt;";
    end else if (item.code_point == CH_QUOT && item.escape_mode == MODE_QUOT) begin
      entity = "&quot;";
    end else if (item.code_point == CH_APOS && item.escape_mode == MODE_APOS) begin
      entity = "&apos;";
    end
    return entity;
  endfunction

  // Queues what an accepted character must produce.
  function automatic void book_expected(xce_in_t item, bit pinned);
    string    entity;
    xce_out_t res;
    entity = escape_char(item);
    if (pinned || entity.len() == 0) begin
      // Pinned rows are pass-through characters whose answer is obvious, so
      // the expectation is written down directly rather than modeled.
      res.out_char    = item.code_point;
      res.last_of_run = 1'b1;
      awaited_chars = {awaited_chars, res};
    end else begin
      for (int k = 0; k < entity.len(); k++) begin
        res.out_char    = CpWidth'(entity[k]);
        res.last_of_run = (k == entity.len() - 1);
        awaited_chars = {awaited_chars, res};
      end
    end
  endfunction

  // Draws the idle cycles before the next transaction of one side, with
  // occasional stretches in which that side never idles.
  function automatic int idle_draw(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) begin
      calm = $urandom_range(5, 30);
      return 0;
    end
    return $urandom_range(0, MaxWait);
  endfunction

  function automatic void add_row(logic [CpWidth-1:0] cp, mode_e mode, bit first, bit pinned);
    char_row_t row;
    row.item.code_point      = cp;
    row.item.escape_mode     = mode;
    row.item.first_of_string = first;
    row.pinned               = pinned;
    directed_rows = {directed_rows, row};
  endfunction

  // Picks a code point for the random strings. Brackets are frequent so
  // that "]]>" shows up often, with the other special characters close
  // behind, plain ASCII, and any 21-bit value now and then.
  function automatic logic [CpWidth-1:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return CH_RBRK;
    if (r < 45) return CH_GT;
    if (r < 52) return CH_LT;
    if (r < 58) return CH_AMP;
    if (r < 66) return CH_QUOT;
    if (r < 74) return CH_APOS;
    if (r < 90) return CpWidth'($urandom_range(32, 126));
    return CpWidth'($urandom);
  endfunction

  // Offers one character on the input channel and returns in the time step
  // of the edge that accepted it. When no gap is drawn, valid simply stays
  // high from the previous transaction.
  task automatic send_char(xce_in_t item, bit pinned);
    int gap;
    gap = idle_draw(calm_in);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    do @(posedge clk); while (!in_ch.ready);
    book_expected(item, pinned);
  endtask

  // Stimulus: the directed table first, then random strings.
  initial begin
    xce_in_t          item;
    mode_e            str_mode;
    int unsigned      sent;
    int unsigned      str_len;
    in_ch.valid  <= 1'b0;
    in_ch.data   <= '0;

    // A '>' right after reset has no bracket history behind it.
    add_row(CH_GT, MODE_TEXT, 1'b0, 1'b1);
    add_row(CpWidth'('h0), MODE_TEXT, 1'b1, 1'b1);
    // Largest field value, beyond Unicode, passes through in the spare mode.
    add_row(CpWidth'('h1FFFFF), MODE_SPARE, 1'b0, 1'b1);
    add_row(CpWidth'('h10FFFF), MODE_QUOT, 1'b1, 1'b1);
    // A surrogate value is not special either.
    add_row(CpWidth'('hD800), MODE_APOS, 1'b0, 1'b1);
    add_row(CpWidth'('h0AAAAA), MODE_TEXT, 1'b0, 1'b0);
    add_row(CpWidth'('h155555), MODE_SPARE, 1'b0, 1'b0);
    // Each replacement but '>', plus quotes that belong to the other mode.
    add_row(CH_LT, MODE_TEXT, 1'b1, 1'b0);
    add_row(CH_AMP, MODE_QUOT, 1'b0, 1'b0);
    add_row(CH_QUOT, MODE_QUOT, 1'b0, 1'b0);
    add_row(CH_APOS, MODE_APOS, 1'b0, 1'b0);
    add_row(CH_QUOT, MODE_APOS, 1'b0, 1'b0);
    add_row(CH_APOS, MODE_QUOT, 1'b0, 1'b0);
    // Three brackets saturate the history; the '>' is still escaped.
    add_row(CH_RBRK, MODE_TEXT, 1'b1, 1'b0);
    add_row(CH_RBRK, MODE_TEXT, 1'b0, 1'b0);
    add_row(CH_RBRK, MODE_TEXT, 1'b0, 1'b0);
    add_row(CH_GT, MODE_TEXT, 1'b0, 1'b0);
    // Brackets seen in attribute mode still count once back in text mode.
    add_row(CH_RBRK, MODE_QUOT, 1'b0, 1'b0);
    add_row(CH_RBRK, MODE_QUOT, 1'b0, 1'b0);
    add_row(CH_GT, MODE_TEXT, 1'b0, 1'b0);
    // A new string clears the history, so this '>' passes through.
    add_row(CH_RBRK, MODE_TEXT, 1'b0, 1'b0);
    add_row(CH_RBRK, MODE_TEXT, 1'b0, 1'b0);
    add_row(CH_GT, MODE_TEXT, 1'b1, 1'b0);
    // The spare mode escapes "]]>" like a text node.
    add_row(CH_RBRK, MODE_SPARE, 1'b1, 1'b0);
    add_row(CH_RBRK, MODE_SPARE, 1'b0, 1'b0);
    add_row(CH_GT, MODE_SPARE, 1'b0, 1'b0);

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      send_char(directed_rows[i].item, directed_rows[i].pinned);
    end

    // Random strings with a steady mode make up most of the traffic. A few
    // characters switch mode mid-string, a few strings lack their start
    // flag, and the flag sometimes appears in the middle of a string.
    sent = 0;
    while (sent < RandomChars) begin
      str_len  = $urandom_range(1, 12);
      str_mode = mode_e'($urandom_range(0, 3));
      for (int k = 0; k < str_len; k++) begin
        item.code_point      = pick_char();
        item.escape_mode     = ($urandom_range(0, 9) == 0) ?
                               ModeWidth'($urandom_range(0, 3)) : str_mode;
        item.first_of_string = (k == 0 && $urandom_range(0, 9) != 0) ||
                               ($urandom_range(0, 29) == 0);
        send_char(item, 1'b0);
        sent++;
      end
    end
    in_ch.valid <= 1'b0;

    // Every owed code point must arrive; the cycle limit catches a hang.
    while (awaited_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("xml_character_escaper_test OK");
    end else begin
      $display("xml_character_escaper_test NOT OK");
    end
    $finish;
  end

  // Receiver: stalls a random number of cycles before each transaction.
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      stall = idle_draw(calm_out);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  // Checks each output transaction against the oldest owed code point.
  // Values read here are the ones present just before the edge.
  always @(posedge clk) begin
    xce_out_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (awaited_chars.size() == 0) begin
        $error("unexpected output transaction: out_char %h last_of_run %b",
               out_ch.data.out_char, out_ch.data.last_of_run);
        mismatch_count++;
      end else begin
        want = awaited_chars.pop_front();
        if (out_ch.data.out_char !== want.out_char) begin
          $error("out_char: expected %h, got %h", want.out_char, out_ch.data.out_char);
          mismatch_count++;
        end
        if (out_ch.data.last_of_run !== want.last_of_run) begin
          $error("last_of_run: expected %b, got %b", want.last_of_run,
                 out_ch.data.last_of_run);
          mismatch_count++;
        end
      end
    end
  end

  // Hang guard.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("xml_character_escaper_test NOT OK");
      $finish;
    end
  end

endmodule

// ----- xml_character_escaper.f -----
hw/rtl/xce_pkg.sv
hw/rtl/xce_stream_if.sv
hw/rtl/xml_character_escaper.sv
sim/xml_character_escaper_test.sv
